### rtl/clp_pkg.sv
// clp_pkg: shared types and constants of the coordinate line parser
// used by clp_ctrl, clp_dp and coordinate_line_parser_top
package clp_pkg;

  localparam int LINE_LEN_DEF    = 32;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_UP_N    = 8'h4e;
  localparam logic [7:0] CH_LO_O    = 8'h6f;
  localparam logic [7:0] CH_LO_N    = 8'h6e;
  localparam logic [7:0] CH_LO_E    = 8'h65;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_UP_Y    = 8'h59;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_COORD   = 2'd1,
    KIND_NOMATCH = 2'd2
  } kind_t;

  typedef struct packed {
    logic rx_write;
    logic rx_newline;
    logic scan_step;
    logic scan_done;
    logic set_none;
    logic set_nomatch;
    logic set_coord;
    logic parse_start;
    logic parse_step;
    logic fwd_done;
    logic rd_prev;
    logic back_step;
    logic commit;
    logic sel_y;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_newline;
    logic scan_end;
    logic byte_zero;
    logic found_none;
    logic found_x;
    logic found_y;
    logic fwd_end;
    logic fwd_stop;
    logic has_dot;
    logic back_end;
  } status_t;

endpackage

### rtl/clp_ctrl.sv
// clp_ctrl: sequencer for byte intake, line scan and value conversion
// depends on clp_pkg
module clp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  clp_pkg::status_t st,
  output clp_pkg::cmd_t    cmd
);
  import clp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_P_RD, S_P_EV, S_B_RD, S_B_EV, S_FIN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_y_r, sel_y_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.sel_y     = sel_y_r;
    state_nxt     = state_r;
    sel_y_nxt     = sel_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (st.is_newline) begin
            cmd.rx_newline = 1'b1;
            state_nxt      = S_SCAN_RD;
          end else begin
            cmd.rx_write = 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
        if (st.scan_end) begin
          cmd.scan_done = 1'b1;
          state_nxt     = S_DECIDE;
        end else begin
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (st.byte_zero) begin
          cmd.scan_done = 1'b1;
          state_nxt     = S_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_DECIDE: begin
        if (st.found_none) begin
          cmd.set_none = 1'b1;
          state_nxt    = S_OUT;
        end else if (st.found_x && st.found_y) begin
          cmd.parse_start = 1'b1;
          cmd.sel_y       = 1'b0;
          sel_y_nxt       = 1'b0;
          state_nxt       = S_P_RD;
        end else begin
          cmd.set_nomatch = 1'b1;
          state_nxt       = S_OUT;
        end
      end
      S_P_RD: begin
        if (st.fwd_end) begin
          cmd.fwd_done = 1'b1;
          state_nxt    = S_B_RD;
        end else begin
          state_nxt = S_P_EV;
        end
      end
      S_P_EV: begin
        if (st.fwd_stop) begin
          cmd.fwd_done = 1'b1;
          state_nxt    = S_B_RD;
        end else begin
          cmd.parse_step = 1'b1;
          state_nxt      = S_P_RD;
        end
      end
      S_B_RD: begin
        if (!st.has_dot || st.back_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_B_EV;
        end
      end
      S_B_EV: begin
        cmd.back_step = 1'b1;
        state_nxt     = S_B_RD;
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        if (sel_y_r) begin
          cmd.set_coord = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          sel_y_nxt = 1'b1;
          state_nxt = S_P_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // second parse starts in the same cycle as the first commit
    if (state_r == S_FIN && !sel_y_r) begin
      cmd.parse_start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_y_r     <= sel_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/clp_dp.sv
// clp_dp: line store, key search, decimal to fixed point conversion, held values
// depends on clp_pkg, driven by clp_ctrl
module clp_dp #(
  parameter int LINE_LEN    = clp_pkg::LINE_LEN_DEF,
  parameter int FRAC_BITS   = clp_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = clp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    rx_byte,
  input  clp_pkg::cmd_t                 cmd,
  output clp_pkg::status_t              st,
  output logic [1:0]                    line_kind,
  output logic                          none_flag,
  output logic signed [VALUE_WIDTH-1:0] x_value,
  output logic signed [VALUE_WIDTH-1:0] y_value
);
  import clp_pkg::*;

  localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
  localparam int PW = $clog2(LINE_LEN + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int FW = FB + 5;
  localparam int SH = FW + 4;
  localparam int PRW = FW + SH + 1;
  localparam logic [VW:0] LIM = (VW + 1)'(1) << (VW - 1);
  localparam logic [VW:0] IP_LIM = LIM / 10;
  localparam logic [VW:0] IP_SAT = LIM >> FB;
  localparam logic [SH:0] RECIP = (((SH + 1)'(1) << SH) + (SH + 1)'(9)) / 10;

  typedef enum logic [1:0] {PH_WS, PH_INT, PH_FRAC} phase_t;

  logic [7:0]    mem_r [LINE_LEN];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] wp_r;
  logic [PW-1:0] ptr_r, lim_r, len_r, px_r, py_r, fs_r;
  logic [7:0]    w1_r, w2_r, w3_r;
  logic          fn_r, fx_r, fy_r;
  phase_t        phase_r;
  logic          neg_r, has_dot_r;
  logic [VW:0]   ip_r;
  logic [FB:0]   frac_r;
  kind_t         kind_r;
  logic [VW-1:0] held_x_r, held_y_r;
  logic          held_none_r;
  logic [1:0]    out_kind_r;
  logic          out_none_r;
  logic [VW-1:0] out_x_r, out_y_r;

  logic [PW-1:0] rd_ptr;
  logic [7:0]    b;
  logic          is_dig, is_ws, is_sign, is_dot, consume;
  logic [3:0]    dig;
  logic [VW:0]   ip_upd;
  logic [FW-1:0] bv;
  logic [PRW-1:0] prod;
  logic [FB+1:0] fr_sum;
  logic [FB:0]   fr;
  logic [VW:0]   mag, mag_neg, mag_pos;
  logic [VW-1:0] value;

  assign rd_ptr  = cmd.rd_prev ? ptr_r - 1'b1 : ptr_r;
  assign b       = rd_data_r;
  assign is_dig  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_ws   = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign is_sign = (b == CH_PLUS) || (b == CH_MINUS);
  assign is_dot  = (b == CH_DOT);
  assign dig     = b[3:0];

  always_comb begin
    case (phase_r)
      PH_WS:   consume = is_ws || is_sign || is_dig || is_dot;
      PH_INT:  consume = is_dig || is_dot;
      PH_FRAC: consume = is_dig;
      default: consume = 1'b0;
    endcase
  end

  assign ip_upd = (ip_r > IP_LIM) ? LIM + 1'b1
                : (ip_r << 3) + (ip_r << 1) + (VW + 1)'(dig);
  assign bv     = (FW'(dig) << (FB + 1)) + FW'(frac_r);
  assign prod   = PRW'(bv) * PRW'(RECIP);
  assign fr_sum = (FB + 2)'(frac_r) + 1'b1;
  assign fr     = fr_sum[FB+1:1];
  assign mag    = (ip_r > IP_SAT) ? LIM : (ip_r << FB) + (VW + 1)'(fr);
  assign mag_neg = (mag > LIM) ? LIM : mag;
  assign mag_pos = (mag > LIM - 1'b1) ? LIM - 1'b1 : mag;
  assign value  = neg_r ? VW'((VW + 1)'(0) - mag_neg) : mag_pos[VW-1:0];

  always_comb begin
    st            = '0;
    st.is_newline = (rx_byte == CH_NEWLINE);
    st.scan_end   = (ptr_r == lim_r);
    st.byte_zero  = (b == 8'd0);
    st.found_none = fn_r;
    st.found_x    = fx_r;
    st.found_y    = fy_r;
    st.fwd_end    = (ptr_r == len_r);
    st.fwd_stop   = !consume;
    st.has_dot    = has_dot_r;
    st.back_end   = (ptr_r == fs_r);
  end

  // line store, synchronous read
  always_ff @(posedge clk) begin
    if (cmd.rx_write) begin
      mem_r[wp_r] <= rx_byte;
    end
    rd_data_r <= mem_r[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_none_r <= 1'b1;
    end else begin
      if (cmd.rx_write) begin
        wp_r <= (wp_r == AW'(LINE_LEN - 1)) ? '0 : wp_r + 1'b1;
      end
      if (cmd.rx_newline) begin
        wp_r <= '0;
      end
      if (cmd.set_none) begin
        held_none_r <= 1'b1;
      end
      if (cmd.set_coord) begin
        held_none_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (cmd.sel_y) begin
          held_y_r <= value;
        end else begin
          held_x_r <= value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_newline) begin
      lim_r <= PW'(wp_r);
      ptr_r <= '0;
      fn_r  <= 1'b0;
      fx_r  <= 1'b0;
      fy_r  <= 1'b0;
      w1_r  <= '0;
      w2_r  <= '0;
      w3_r  <= '0;
    end
    if (cmd.scan_step) begin
      if (!fn_r && w3_r == CH_UP_N && w2_r == CH_LO_O && w1_r == CH_LO_N && b == CH_LO_E) begin
        fn_r <= 1'b1;
      end
      if (!fx_r && w1_r == CH_UP_X && b == CH_EQ) begin
        fx_r <= 1'b1;
        px_r <= ptr_r + 1'b1;
      end
      if (!fy_r && w1_r == CH_UP_Y && b == CH_EQ) begin
        fy_r <= 1'b1;
        py_r <= ptr_r + 1'b1;
      end
      w3_r  <= w2_r;
      w2_r  <= w1_r;
      w1_r  <= b;
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.scan_done) begin
      len_r <= ptr_r;
    end
    if (cmd.parse_start) begin
      // the Y parse starts in the same cycle as the X commit
      ptr_r     <= cmd.commit ? py_r : px_r;
      phase_r   <= PH_WS;
      neg_r     <= 1'b0;
      has_dot_r <= 1'b0;
      ip_r      <= '0;
      frac_r    <= '0;
      fs_r      <= '0;
    end
    if (cmd.parse_step) begin
      ptr_r <= ptr_r + 1'b1;
      if (is_dig) begin
        if (phase_r != PH_FRAC) begin
          ip_r    <= ip_upd;
          phase_r <= PH_INT;
        end
      end else if (is_dot) begin
        phase_r   <= PH_FRAC;
        has_dot_r <= 1'b1;
        fs_r      <= ptr_r + 1'b1;
      end else if (is_sign) begin
        neg_r   <= (b == CH_MINUS);
        phase_r <= PH_INT;
      end
    end
    if (cmd.back_step) begin
      frac_r <= prod[SH+FB:SH];
      ptr_r  <= ptr_r - 1'b1;
    end
    if (cmd.set_none) begin
      kind_r <= KIND_NONE;
    end
    if (cmd.set_nomatch) begin
      kind_r <= KIND_NOMATCH;
    end
    if (cmd.set_coord) begin
      kind_r <= KIND_COORD;
    end
    if (cmd.load_out) begin
      out_kind_r <= kind_r;
      out_none_r <= held_none_r;
      out_x_r    <= held_x_r;
      out_y_r    <= held_y_r;
    end
  end

  assign line_kind = out_kind_r;
  assign none_flag = out_none_r;
  assign x_value   = out_x_r;
  assign y_value   = out_y_r;

endmodule

### rtl/coordinate_line_parser_top.sv
// coordinate_line_parser_top: top level of the coordinate line parser
// depends on clp_pkg, clp_ctrl and clp_dp
//
// input channel: one received character per request on in_rx_byte
// (in_valid / in_stall). ordinary characters go into a line store of
// LINE_LEN entries, one per cycle, and produce no result. a newline ends
// the line and produces exactly one result request on the out_ channel:
// line kind, held none flag and held X and Y in signed fixed point.
// after a newline the block raises in_stall while it walks the line:
// a key scan over the stored bytes, then per value a forward pass over
// its characters and a backward pass over its fraction digits, one
// byte at a time through the single read port of the line store.
// the result sits in an output register until taken; ordinary characters
// are taken meanwhile, a later newline waits at the end of its walk while
// the receiver stalls.
// reset clears the write index, X and Y to zero and sets the none flag.
module coordinate_line_parser_top #(
  parameter int LINE_LEN    = clp_pkg::LINE_LEN_DEF,
  parameter int FRAC_BITS   = clp_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = clp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_line_kind,
  output logic                          out_none_flag,
  output logic signed [VALUE_WIDTH-1:0] out_x_value,
  output logic signed [VALUE_WIDTH-1:0] out_y_value
);
  import clp_pkg::*;

  cmd_t    cmd;
  status_t st;

  clp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  clp_dp #(
    .LINE_LEN    (LINE_LEN),
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_rx_byte),
    .cmd       (cmd),
    .st        (st),
    .line_kind (out_line_kind),
    .none_flag (out_none_flag),
    .x_value   (out_x_value),
    .y_value   (out_y_value)
  );

endmodule

### bench/coordinate_line_parser_top_test.sv
// coordinate_line_parser_top_test: self-checking bench for coordinate_line_parser_top
// depends on clp_pkg and the rtl of coordinate_line_parser_top
// directed lines from a table, then random lines, checked against typed table results or an in-bench line parser
module coordinate_line_parser_top_test;
  import clp_pkg::*;

  localparam int LLEN = 32;
  localparam int FBITS = 8;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic [1:0]  kind;
    logic        none_flag;
    logic [31:0] x;
    logic [31:0] y;
  } line_result_t;

  typedef struct {
    string       txt;
    bit          typed;
    kind_t       kind;
    bit          none_flag;
    logic [31:0] x;
    logic [31:0] y;
  } dir_row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] in_rx_byte;
  logic [1:0] out_line_kind;
  logic out_none_flag;
  logic signed [31:0] out_x_value, out_y_value;

  logic [7:0]  line_buf [LLEN];
  int          wr_pos;
  logic [31:0] cur_x, cur_y;
  logic        cur_none;

  line_result_t pending_results[$];
  bit           failed;
  bit           hold_req;
  int           idle_cycles;

  coordinate_line_parser_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_line_kind(out_line_kind), .out_none_flag(out_none_flag),
    .out_x_value(out_x_value), .out_y_value(out_y_value)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int find_key(int len, string key);
    int j;
    for (int i = 0; i + key.len() <= len; i++) begin
      for (j = 0; j < key.len(); j++)
        if (line_buf[i + j] != key[j]) break;
      if (j == key.len()) return i;
    end
    return len + 1;
  endfunction

  function automatic bit digit_at(int p, int len);
    return p < len && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE;
  endfunction

  function automatic logic [31:0] value_at(int p, int len);
    longint unsigned lim, ip, frac, mag, d;
    bit neg;
    int fs, fe;
    lim = 64'd1 << 31;
    ip = 0;
    frac = 0;
    neg = 0;
    while (p < len && (line_buf[p] == CH_SPACE ||
           (line_buf[p] >= CH_TAB && line_buf[p] <= CH_CR)))
      p++;
    if (p < len && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS)) begin
      neg = line_buf[p] == CH_MINUS;
      p++;
    end
    while (digit_at(p, len)) begin
      if (ip > lim / 10) ip = lim + 1;
      else ip = ip * 10 + (line_buf[p] - CH_ZERO);
      p++;
    end
    if (p < len && line_buf[p] == CH_DOT) begin
      p++;
      fs = p;
      while (digit_at(p, len)) p++;
      fe = p;
      for (int i = fe; i > fs; i--) begin
        d = line_buf[i - 1] - CH_ZERO;
        frac = ((d << (FBITS + 1)) + frac) / 10;
      end
    end
    frac = (frac + 1) >> 1;
    if (ip > (lim >> FBITS)) mag = lim;
    else mag = (ip << FBITS) + frac;
    if (neg) begin
      if (mag > lim) mag = lim;
      return 32'(64'd0 - mag);
    end
    if (mag > lim - 1) mag = lim - 1;
    return 32'(mag);
  endfunction

  // returns 1 when the character closes a line
  function automatic bit parse_char(logic [7:0] c, output line_result_t r);
    int len, pn, px, py;
    if (c != CH_NEWLINE) begin
      line_buf[wr_pos] = c;
      wr_pos = (wr_pos + 1) % LLEN;
      return 0;
    end
    len = wr_pos;
    for (int i = 0; i < wr_pos; i++)
      if (line_buf[i] == 8'd0) begin
        len = i;
        break;
      end
    wr_pos = 0;
    pn = find_key(len, "None");
    px = find_key(len, "X=");
    py = find_key(len, "Y=");
    if (pn <= len) begin
      cur_none = 1;
      r.kind = KIND_NONE;
    end else if (px <= len && py <= len) begin
      cur_x = value_at(px + 2, len);
      cur_y = value_at(py + 2, len);
      cur_none = 0;
      r.kind = KIND_COORD;
    end else begin
      r.kind = KIND_NOMATCH;
    end
    r.none_flag = cur_none;
    r.x = cur_x;
    r.y = cur_y;
    return 1;
  endfunction

  task automatic send_char(logic [7:0] c, bit typed, line_result_t typed_res);
    line_result_t r;
    int gap;
    in_valid <= 1;
    in_rx_byte <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_char(c, r)) pending_results.push_back(typed ? typed_res : r);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: gap = 0;
      5, 6, 7: gap = $urandom_range(1, 3);
      8: gap = $urandom_range(4, 12);
      default: gap = $urandom_range(30, 150);
    endcase
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_line(logic [7:0] bytes[$]);
    line_result_t dummy;
    foreach (bytes[i]) send_char(bytes[i], 0, dummy);
    send_char(CH_NEWLINE, 0, dummy);
  endtask

  function automatic void add_number(ref logic [7:0] q[$]);
    int nd;
    repeat ($urandom_range(0, 2)) q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(0, 3))
      0: q.push_back(CH_MINUS);
      1: q.push_back(CH_PLUS);
      default: ;
    endcase
    nd = $urandom_range(0, 9) == 0 ? $urandom_range(8, 11) : $urandom_range(0, 4);
    repeat (nd) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 1)) begin
      q.push_back(CH_DOT);
      repeat ($urandom_range(0, 5)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  function automatic void make_line(ref logic [7:0] q[$]);
    int mode;
    mode = $urandom_range(0, 19);
    q = {};
    if (mode < 12) begin
      q = {CH_UP_X, CH_EQ};
      add_number(q);
      q.push_back(CH_SPACE);
      q.push_back(CH_UP_Y);
      q.push_back(CH_EQ);
      add_number(q);
      if (mode == 0) q = {q[3:$], q[0:2]};
      if (mode == 1) q.insert($urandom_range(0, q.size()), 8'd0);
    end else if (mode < 14) begin
      q = {CH_UP_N, CH_LO_O, CH_LO_N, CH_LO_E};
      if (mode == 13) q = {CH_UP_X, CH_EQ, CH_ZERO + 8'd1, CH_SPACE, q};
    end else if (mode < 16) begin
      q = {CH_UP_Y, CH_EQ};
      add_number(q);
      if (mode == 15) q = {CH_UP_X, CH_UP_Y, CH_EQ, CH_ZERO};
    end else if (mode < 18) begin
      repeat ($urandom_range(0, 40)) begin
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        q.push_back(b == CH_NEWLINE ? CH_SPACE : b);
      end
    end else begin
      repeat ($urandom_range(20, 45)) q.push_back(CH_LO_E);
      q = {q, CH_UP_X, CH_EQ, CH_ZERO + 8'd4, CH_UP_Y, CH_EQ, CH_MINUS, CH_ZERO + 8'd2};
    end
  endfunction

  dir_row_t dir_rows[] = '{
    '{"", 1, KIND_NOMATCH, 1, 32'd0, 32'd0},
    '{"None", 1, KIND_NONE, 1, 32'd0, 32'd0},
    '{"X=1 Y=-1", 1, KIND_COORD, 0, 32'h00000100, 32'hffffff00},
    '{"X=99999999 Y=-99999999", 1, KIND_COORD, 0, 32'h7fffffff, 32'h80000000},
    '{"X=8388607.999 Y=-8388608", 1, KIND_COORD, 0, 32'h7fffffff, 32'h80000000},
    '{"X=0.5 Y=.001", 0, KIND_COORD, 0, 32'd0, 32'd0},
    '{"X= Y=", 1, KIND_COORD, 0, 32'd0, 32'd0},
    '{"Y=-2.5X=+3", 0, KIND_COORD, 0, 32'd0, 32'd0},
    '{"X=-  Y=.", 1, KIND_COORD, 0, 32'd0, 32'd0},
    '{"ZZZ", 1, KIND_NOMATCH, 0, 32'd0, 32'd0},
    '{"X=1", 0, KIND_NOMATCH, 0, 32'd0, 32'd0},
    '{"X=5 None Y=6", 0, KIND_NONE, 0, 32'd0, 32'd0},
    '{"X=1@ Y=2", 0, KIND_NOMATCH, 0, 32'd0, 32'd0},
    '{"AAAAAAAAAAAAAAAAAAAAAAAAAAAAAAX=7 Y=8", 0, KIND_COORD, 0, 32'd0, 32'd0},
    '{"X=1 Y=2 BBBBBBBBBBBBBBBBBBBBBBBB", 0, KIND_NOMATCH, 0, 32'd0, 32'd0},
    '{"\tX=\t 12.75 Y=  -0.00195", 0, KIND_COORD, 0, 32'd0, 32'd0},
    '{"X=2147483647.9 Y=-0.001", 0, KIND_COORD, 0, 32'd0, 32'd0},
    '{"X=ab Y=+", 0, KIND_COORD, 0, 32'd0, 32'd0}
  };

  // directed table then random lines, with a long receiver hold and a drain partway through
  initial begin
    logic [7:0] q[$];
    line_result_t tr, dummy;
    int sent;
    bit drained;
    in_valid = 0;
    in_rx_byte = 0;
    rst_n = 0;
    hold_req = 0;
    failed = 0;
    drained = 0;
    wr_pos = 0;
    cur_x = 0;
    cur_y = 0;
    cur_none = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      // '@' stands for a zero byte
      for (int k = 0; k < dir_rows[i].txt.len(); k++)
        send_char(dir_rows[i].txt[k] == "@" ? 8'd0 : dir_rows[i].txt[k], 0, dummy);
      tr = '{dir_rows[i].kind, dir_rows[i].none_flag, dir_rows[i].x, dir_rows[i].y};
      send_char(CH_NEWLINE, dir_rows[i].typed, tr);
    end
    sent = 0;
    while (sent < 590) begin
      if (sent > 200 && sent < 260 && !hold_req) hold_req <= 1;
      if (sent > 400 && !drained) begin
        in_valid <= 0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        drained = 1;
      end
      make_line(q);
      send_line(q);
      sent += q.size() + 1;
    end
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // receiver stalls, with a long hold-off while hold_req is set
  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (2500) @(posedge clk);
        hold_req <= 0;
        out_stall <= 0;
        repeat (2000) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: out_stall <= 0;
          6, 7, 8: out_stall <= 1;
          default: begin
            out_stall <= 1;
            repeat ($urandom_range(20, 200)) @(posedge clk);
            out_stall <= 0;
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    line_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result request with no line pending");
        failed = 1;
      end else begin
        e = pending_results.pop_front();
        if (out_line_kind !== e.kind) begin
          $error("line_kind expected %0d got %0d", e.kind, out_line_kind);
          failed = 1;
        end
        if (out_none_flag !== e.none_flag) begin
          $error("none_flag expected %0d got %0d", e.none_flag, out_none_flag);
          failed = 1;
        end
        if (out_x_value !== e.x) begin
          $error("x_value expected %h got %h", e.x, out_x_value);
          failed = 1;
        end
        if (out_y_value !== e.y) begin
          $error("y_value expected %h got %h", e.y, out_y_value);
          failed = 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
